### rtl/stack_vm_instruction_executor_assert.svh
// ---------------------------------------------------------------------------
// Stack VM executor assertion macros
// Shared property wrappers, clocked on clk and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define STACK_VM_INSTRUCTION_EXECUTOR_ASSERT_SVH

// implication checked on every rising edge outside reset
`define SVM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define SVM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/svm_pkg.sv
// ---------------------------------------------------------------------------
// Stack VM executor package
// Opcodes, error codes, controller states and the control/status bundles.
// ---------------------------------------------------------------------------
package svm_pkg;

	localparam int MEM_WORDS  = 65536;
	localparam int MEM_AW     = $clog2(MEM_WORDS);
	localparam int PROG_DEPTH = 4096;
	localparam int PC_W       = 12;
	localparam int DW         = 32;
	localparam int SW         = 19;
	localparam int REG_COUNT  = 7;

	localparam logic [2:0]    REG_ACC    = 3'd1;
	localparam logic [2:0]    REG_STACK  = 3'd5;
	localparam logic [2:0]    SEL_IMM    = 3'd7;
	localparam logic [DW-1:0] STACK_RST  = 32'd262144;
	localparam logic [DW-1:0] WORD_BYTES = 32'd4;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,  OP_SUB  = 5'd1,  OP_MUL  = 5'd2,  OP_DIV  = 5'd3,
		OP_REM  = 5'd4,  OP_MOV  = 5'd5,  OP_PUSH = 5'd6,  OP_POP  = 5'd7,
		OP_LOAD = 5'd8,  OP_SAVE = 5'd9,  OP_NE   = 5'd10, OP_EQ   = 5'd11,
		OP_GT   = 5'd12, OP_GE   = 5'd13, OP_LT   = 5'd14, OP_LE   = 5'd15,
		OP_RET  = 5'd16, OP_JZ   = 5'd17, OP_JUMP = 5'd18, OP_CALL = 5'd19
	} op_t;

	typedef enum logic [2:0] {
		ERR_OK    = 3'd0,
		ERR_DIV0  = 3'd1,
		ERR_OPC   = 3'd2,
		ERR_SIZE  = 3'd3,
		ERR_RANGE = 3'd4
	} err_t;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_EXEC, ST_MEM, ST_DIV, ST_DWB
	} state_t;

	typedef struct packed {
		logic load;
		logic mem_rd;
		logic div_start;
		logic commit;
		logic clr_en;
	} svm_cmd_t;

	typedef struct packed {
		logic needs_mem;
		logic needs_div;
		logic div_busy;
		logic out_free;
		logic clr_last;
	} svm_sts_t;

endpackage

### rtl/stack_vm_instruction_executor.sv
// ---------------------------------------------------------------------------
// Stack VM instruction executor
// Executes one decoded instruction per input beat, one result beat each.
// ---------------------------------------------------------------------------
// After reset the block zeroes the data memory, one word per cycle, with
// s_tready low; the stack_top write channel is always ready. Register,
// move, compare, jump, push, save and call instructions are captured with
// a registered register read, then executed and committed; pop, load and
// ret add a registered data-memory read before the commit; div and rem
// run the 32-step shift-subtract divider and commit once it has finished.
// Any faulting instruction commits straight from execute. A result waiting
// in the output register holds off only the next commit, not the capture
// of the next instruction.
`include "stack_vm_instruction_executor_assert.svh"

module stack_vm_instruction_executor
	import svm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // dest_reg, src1_reg, src2_sel, immediate, program_counter, pad
	input  logic [4:0]  s_tuser,  // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // next_pc, written_value, error_code, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [18:0] cfg_data  // stack_top
);

	svm_cmd_t        cmd;
	svm_sts_t        sts;
	logic [PC_W-1:0] out_npc;
	logic [DW-1:0]   out_val;
	logic [2:0]      out_err;

	assign cfg_ready = 1'b1;

	svm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	svm_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_op     (s_tuser),
		.in_dst    (s_tdata[2:0]),
		.in_src1   (s_tdata[5:3]),
		.in_src2   (s_tdata[8:6]),
		.in_imm    (s_tdata[40:9]),
		.in_pc     (s_tdata[52:41]),
		.cfg_we    (cfg_valid),
		.cfg_wdata (cfg_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_npc   (out_npc),
		.out_val   (out_val),
		.out_err   (out_err)
	);

	assign m_tdata = {1'b0, out_err, out_val, out_npc};

	// controller and datapath consistency
	`SVM_ASSERT_IMPL(a_no_accept_while_dividing, s_tready, !sts.div_busy,
		"instruction accepted while divider busy")
	`SVM_ASSERT_IMPL(a_commit_needs_slot, cmd.commit, sts.out_free,
		"commit with output register still occupied")
	`SVM_ASSERT_NEXT(a_div_runs, cmd.div_start, sts.div_busy,
		"divider did not start")
	`SVM_ASSERT_NEXT(a_commit_shows, cmd.commit, m_tvalid,
		"committed result not presented")

endmodule

### rtl/svm_div.sv
// ---------------------------------------------------------------------------
// Stack VM unsigned divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module svm_div
	import svm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [DW-1:0] quot,
	output logic [DW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW:0]   shifted;
	logic [DW+1:0] trial;

	// one shift-and-subtract step
	assign shifted = {rem_q, quo_q[DW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor};

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q  <= cnt_q - CW'(1);
			busy_q <= (cnt_q != CW'(1));
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (!trial[DW+1]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

### rtl/svm_ctrl.sv
// ---------------------------------------------------------------------------
// Stack VM controller
// Sequences memory clear, instruction capture, execute, memory read, divide and commit.
// ---------------------------------------------------------------------------
module svm_ctrl
	import svm_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  svm_sts_t sts,
	output svm_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sts.clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				if (sts.needs_div)      state_d = ST_DIV;
				else if (sts.needs_mem) state_d = ST_MEM;
				else if (sts.out_free)  state_d = ST_IDLE;
			end
			ST_MEM:   if (sts.out_free) state_d = ST_IDLE;
			ST_DIV:   if (!sts.div_busy) state_d = ST_DWB;
			ST_DWB:   if (sts.out_free) state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: cmd.clr_en = 1'b1;
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EXEC: begin
				cmd.div_start = sts.needs_div;
				cmd.mem_rd    = sts.needs_mem && !sts.needs_div;
				cmd.commit    = !sts.needs_div && !sts.needs_mem && sts.out_free;
			end
			ST_MEM:  cmd.commit = sts.out_free;
			ST_DIV:  cmd      = '0;
			ST_DWB:  cmd.commit = sts.out_free;
			default: cmd      = '0;
		endcase
	end

endmodule

### rtl/svm_dp.sv
// ---------------------------------------------------------------------------
// Stack VM datapath
// Register file, data memory, ALU, address checks and the result register.
// ---------------------------------------------------------------------------
module svm_dp
	import svm_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  svm_cmd_t      cmd,
	output svm_sts_t      sts,
	input  logic [4:0]    in_op,
	input  logic [2:0]    in_dst,
	input  logic [2:0]    in_src1,
	input  logic [2:0]    in_src2,
	input  logic [DW-1:0] in_imm,
	input  logic [PC_W-1:0] in_pc,
	input  logic          cfg_we,
	input  logic [SW-1:0] cfg_wdata,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [PC_W-1:0] out_npc,
	output logic [DW-1:0] out_val,
	output logic [2:0]    out_err
);

	logic [DW-1:0]   rf_q [REG_COUNT];
	logic [DW-1:0]   mem  [MEM_WORDS];

	op_t             op_q;
	logic [2:0]      dst_q, s2_q;
	logic [DW-1:0]   imm_q, a_q, r2_q, rd_q;
	logic [PC_W-1:0] pc_q;
	logic [MEM_AW-1:0] clr_idx_q;
	logic            ov_q;
	logic [PC_W-1:0] onpc_q;
	logic [DW-1:0]   oval_q;
	logic [2:0]      oerr_q;

	logic [2:0]      rd2_addr;
	logic [DW-1:0]   b, sp, acc, addr, mag_a, mag_b, dquot, drem, div_val;
	logic            addr_ok, div_busy;
	logic [MEM_AW-1:0] idx, waddr;
	err_t            err;
	logic [DW-1:0]   val, sp_val, mem_wdata;
	logic [PC_W-1:0] npc, pc_inc;
	logic            reg_we, sp_we, mem_wr, ok, mem_we;

	// instruction capture with registered register-file reads
	assign rd2_addr = (in_op == OP_SAVE) ? in_dst : in_src2;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_op);
			dst_q <= in_dst;
			s2_q  <= in_src2;
			imm_q <= in_imm;
			pc_q  <= in_pc;
			a_q   <= (in_src1 == SEL_IMM) ? '0 : rf_q[in_src1];
			r2_q  <= (rd2_addr == SEL_IMM) ? '0 : rf_q[rd2_addr];
		end
	end

	// operands
	assign b      = (s2_q == SEL_IMM) ? imm_q : r2_q;
	assign sp     = rf_q[REG_STACK];
	assign acc    = rf_q[REG_ACC];
	assign pc_inc = pc_q + PC_W'(1);

	// byte address to word index
	always_comb begin
		case (op_q)
			OP_PUSH, OP_CALL: addr = sp - WORD_BYTES;
			OP_LOAD:          addr = a_q;
			OP_SAVE:          addr = r2_q;
			default:          addr = sp;
		endcase
	end
	assign addr_ok = (addr[DW-1:MEM_AW+2] == '0);
	assign idx     = addr[MEM_AW+1:2];

	// fault detection
	always_comb begin
		case (op_q)
			OP_ADD, OP_SUB, OP_MUL, OP_MOV, OP_NE, OP_EQ, OP_GT, OP_GE, OP_LT,
			OP_LE, OP_JZ, OP_JUMP: err = ERR_OK;
			OP_DIV, OP_REM: err = (b == '0) ? ERR_DIV0 : ERR_OK;
			OP_PUSH, OP_POP, OP_RET, OP_CALL: err = addr_ok ? ERR_OK : ERR_RANGE;
			OP_LOAD, OP_SAVE: begin
				if (imm_q != WORD_BYTES) err = ERR_SIZE;
				else if (!addr_ok)       err = ERR_RANGE;
				else                     err = ERR_OK;
			end
			default: err = ERR_OPC;
		endcase
	end
	assign ok = (err == ERR_OK);

	// signed divide on magnitudes
	assign mag_a = a_q[DW-1] ? -a_q : a_q;
	assign mag_b = b[DW-1] ? -b : b;

	svm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (mag_a),
		.divisor  (mag_b),
		.busy     (div_busy),
		.quot     (dquot),
		.rem      (drem)
	);

	always_comb begin
		if (op_q == OP_DIV) div_val = (a_q[DW-1] ^ b[DW-1]) ? -dquot : dquot;
		else                div_val = a_q[DW-1] ? -drem : drem;
	end

	// result selection
	always_comb begin
		val       = '0;
		npc       = pc_inc;
		reg_we    = 1'b0;
		sp_we     = 1'b0;
		sp_val    = sp;
		mem_wr    = 1'b0;
		mem_wdata = b;
		case (op_q)
			OP_ADD: begin val = a_q + b; reg_we = 1'b1; end
			OP_SUB: begin val = a_q - b; reg_we = 1'b1; end
			OP_MUL: begin val = a_q * b; reg_we = 1'b1; end
			OP_DIV, OP_REM: begin val = div_val; reg_we = 1'b1; end
			OP_MOV: begin val = b; reg_we = 1'b1; end
			OP_NE: begin val = DW'($signed(a_q) != $signed(b)); reg_we = 1'b1; end
			OP_EQ: begin val = DW'($signed(a_q) == $signed(b)); reg_we = 1'b1; end
			OP_GT: begin val = DW'($signed(a_q) >  $signed(b)); reg_we = 1'b1; end
			OP_GE: begin val = DW'($signed(a_q) >= $signed(b)); reg_we = 1'b1; end
			OP_LT: begin val = DW'($signed(a_q) <  $signed(b)); reg_we = 1'b1; end
			OP_LE: begin val = DW'($signed(a_q) <= $signed(b)); reg_we = 1'b1; end
			OP_PUSH: begin
				val    = b;
				mem_wr = 1'b1;
				sp_we  = 1'b1;
				sp_val = sp - WORD_BYTES;
			end
			OP_POP: begin
				val    = rd_q;
				reg_we = 1'b1;
				sp_we  = 1'b1;
				sp_val = ((dst_q == REG_STACK) ? rd_q : sp) + WORD_BYTES;
			end
			OP_LOAD: begin val = rd_q; reg_we = 1'b1; end
			OP_SAVE: begin
				val       = a_q;
				mem_wr    = 1'b1;
				mem_wdata = a_q;
			end
			OP_RET: begin
				npc    = rd_q[PC_W-1:0];
				sp_we  = 1'b1;
				sp_val = sp + WORD_BYTES;
			end
			OP_JZ:   if (acc == '0) npc = imm_q[PC_W-1:0];
			OP_JUMP: npc = imm_q[PC_W-1:0];
			OP_CALL: begin
				val       = DW'({1'b0, pc_q} + (PC_W+1)'(1));
				mem_wr    = 1'b1;
				mem_wdata = val;
				sp_we     = 1'b1;
				sp_val    = sp - WORD_BYTES;
				npc       = imm_q[PC_W-1:0];
			end
			default: val = '0;
		endcase
	end

	// register file: reset, config load and commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				rf_q[i] <= (3'(i) == REG_STACK) ? STACK_RST : '0;
			end
		end else if (cfg_we) begin
			rf_q[REG_STACK] <= DW'(cfg_wdata);
		end else if (cmd.commit && ok) begin
			if (reg_we && dst_q != SEL_IMM) rf_q[dst_q] <= val;
			if (sp_we) rf_q[REG_STACK] <= sp_val;
		end
	end

	// clearing pass index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
		end else if (cmd.clr_en) begin
			clr_idx_q <= clr_idx_q + MEM_AW'(1);
		end
	end

	// data memory, one write and one registered read port
	assign mem_we = cmd.clr_en || (cmd.commit && ok && mem_wr);
	assign waddr  = cmd.clr_en ? clr_idx_q : idx;

	always_ff @(posedge clk) begin
		if (mem_we) mem[waddr] <= cmd.clr_en ? '0 : mem_wdata;
		if (cmd.mem_rd) rd_q <= mem[idx];
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.commit) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			onpc_q <= ok ? npc : pc_q;
			oval_q <= ok ? val : '0;
			oerr_q <= err;
		end
	end

	assign out_valid = ov_q;
	assign out_npc   = onpc_q;
	assign out_val   = oval_q;
	assign out_err   = oerr_q;

	// status to controller
	always_comb begin
		sts           = '0;
		sts.needs_mem = ok && (op_q == OP_POP || op_q == OP_LOAD || op_q == OP_RET);
		sts.needs_div = ok && (op_q == OP_DIV || op_q == OP_REM);
		sts.div_busy  = div_busy;
		sts.out_free  = !ov_q || out_ready;
		sts.clr_last  = (clr_idx_q == '1);
	end

endmodule

### test/stack_vm_instruction_executor_tb.sv
// ---------------------------------------------------------------------------
// Stack VM instruction executor testbench
// Streams directed and random instructions through the executor, predicts
// each result from a local copy of the registers and data memory, and
// compares every result beat field by field in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_vm_instruction_executor_tb;
	import svm_pkg::*;

	typedef struct {
		logic [4:0]  op;
		logic [2:0]  dst;
		logic [2:0]  s1;
		logic [2:0]  s2;
		logic [31:0] imm;
		logic [11:0] pc;
	} instr_t;

	typedef struct {
		logic [11:0] npc;
		logic [31:0] val;
		logic [2:0]  err;
	} outcome_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [55:0] s_tdata;   // dest_reg, src1_reg, src2_sel, immediate, program_counter, pad
	logic [4:0]  s_tuser;   // operation
	logic        m_tvalid;
	logic        m_tready;
	logic [47:0] m_tdata;   // next_pc, written_value, error_code, pad
	logic        cfg_valid;
	logic        cfg_ready;
	logic [18:0] cfg_data;  // stack_top

	stack_vm_instruction_executor dut (.*);

	// predictor state
	logic [31:0] vm_regs [REG_COUNT];
	logic [31:0] vm_mem [MEM_WORDS];

	instr_t   pending_instrs[$];
	outcome_t expected_outcomes[$];
	int       mismatches;
	int       idle_cycles;
	int       send_gap;
	int       recv_gap;
	bit       stim_done;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] rd_reg(logic [2:0] idx);
		return (idx < REG_COUNT) ? vm_regs[idx] : 32'd0;
	endfunction

	function automatic bit addr_ok(logic [31:0] addr);
		return !addr[31] && ((addr >> 2) < MEM_WORDS);
	endfunction

	// executes one instruction against the predictor state
	function automatic outcome_t execute_instr(instr_t ins);
		outcome_t r;
		logic [31:0] a, b, sp, v;
		logic signed [31:0] sa, sb;
		logic [31:0] npc;
		logic [2:0] err;
		a = rd_reg(ins.s1);
		b = (ins.s2 == SEL_IMM) ? ins.imm : rd_reg(ins.s2);
		sa = a;
		sb = b;
		sp = vm_regs[REG_STACK];
		npc = {20'd0, ins.pc} + 32'd1;
		v = 32'd0;
		err = ERR_OK;
		case (ins.op)
			OP_ADD: v = a + b;
			OP_SUB: v = a - b;
			OP_MUL: v = a * b;
			OP_DIV, OP_REM: begin
				if (b == 0) err = ERR_DIV0;
				else if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
					v = (ins.op == OP_DIV) ? 32'h8000_0000 : 32'd0;
				else v = (ins.op == OP_DIV) ? sa / sb : sa % sb;
			end
			OP_MOV: v = b;
			OP_PUSH, OP_CALL: begin
				if (!addr_ok(sp - 4)) err = ERR_RANGE;
				else begin
					v = (ins.op == OP_PUSH) ? b : npc;
					vm_mem[(sp - 4) >> 2] = v;
					vm_regs[REG_STACK] = sp - 4;
					if (ins.op == OP_CALL) npc = ins.imm;
				end
			end
			OP_POP: begin
				if (!addr_ok(sp)) err = ERR_RANGE;
				else v = vm_mem[sp >> 2];
			end
			OP_LOAD: begin
				if (ins.imm != WORD_BYTES) err = ERR_SIZE;
				else if (!addr_ok(a)) err = ERR_RANGE;
				else v = vm_mem[a >> 2];
			end
			OP_SAVE: begin
				if (ins.imm != WORD_BYTES) err = ERR_SIZE;
				else if (!addr_ok(rd_reg(ins.dst))) err = ERR_RANGE;
				else begin
					v = a;
					vm_mem[rd_reg(ins.dst) >> 2] = a;
				end
			end
			OP_NE: v = {31'd0, sa != sb};
			OP_EQ: v = {31'd0, sa == sb};
			OP_GT: v = {31'd0, sa > sb};
			OP_GE: v = {31'd0, sa >= sb};
			OP_LT: v = {31'd0, sa < sb};
			OP_LE: v = {31'd0, sa <= sb};
			OP_RET: begin
				if (!addr_ok(sp)) err = ERR_RANGE;
				else begin
					npc = vm_mem[sp >> 2];
					vm_regs[REG_STACK] = sp + 4;
				end
			end
			OP_JZ: if (vm_regs[REG_ACC] == 0) npc = ins.imm;
			OP_JUMP: npc = ins.imm;
			default: err = ERR_OPC;
		endcase
		// register writeback for the value-producing operations
		if (err == ERR_OK) begin
			case (ins.op)
				OP_PUSH, OP_CALL, OP_SAVE, OP_RET, OP_JZ, OP_JUMP: ;
				OP_POP: begin
					if (ins.dst < REG_COUNT) vm_regs[ins.dst] = v;
					vm_regs[REG_STACK] = vm_regs[REG_STACK] + 4;
				end
				default: if (ins.dst < REG_COUNT) vm_regs[ins.dst] = v;
			endcase
		end else begin
			npc = ins.pc;
			v = 32'd0;
		end
		r.npc = npc[11:0];
		r.val = v;
		r.err = err;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		mismatches++;
	endtask

	task automatic add_instr(logic [4:0] op, logic [2:0] dst, logic [2:0] s1,
			logic [2:0] s2, logic [31:0] imm);
		instr_t ins;
		ins.op = op;
		ins.dst = dst;
		ins.s1 = s1;
		ins.s2 = s2;
		ins.imm = imm;
		ins.pc = 12'($urandom);
		pending_instrs.push_back(ins);
	endtask

	task automatic wait_drained();
		while (pending_instrs.size() != 0 || s_tvalid || expected_outcomes.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_stack_top(logic [18:0] value);
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		for (int i = 0; i < REG_COUNT; i++) if (i == REG_STACK) vm_regs[i] = {13'd0, value};
	endtask

	// random instruction; mostly valid with small stack and memory addresses
	task automatic add_random();
		logic [4:0] op;
		logic [31:0] imm;
		int k;
		k = $urandom_range(0, 99);
		op = (k < 4) ? 5'($urandom_range(20, 31)) : 5'($urandom_range(0, 19));
		case ($urandom_range(0, 5))
			0: imm = $urandom;
			1: imm = 32'($urandom_range(0, 64)) << 2;
			2: imm = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0};
			3: imm = 32'h8000_0000 | 32'($urandom_range(0, 1));
			default: imm = 32'($urandom_range(0, 8));
		endcase
		if ((op == OP_LOAD || op == OP_SAVE) && $urandom_range(0, 3) != 0) imm = WORD_BYTES;
		add_instr(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
			3'($urandom_range(0, 7)), imm);
	endtask

	// stimulus
	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		mismatches = 0;
		stim_done = 0;
		foreach (vm_regs[i]) vm_regs[i] = 32'd0;
		foreach (vm_mem[i]) vm_mem[i] = 32'd0;
		vm_regs[REG_STACK] = STACK_RST;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: stack at the top extreme then the extremes of fields
		add_instr(OP_PUSH, 0, 0, SEL_IMM, 32'h1234);
		add_instr(OP_POP, 2, 0, 0, 0);
		add_instr(OP_RET, 0, 0, 0, 0);
		add_instr(OP_MOV, 1, 0, SEL_IMM, 32'h8000_0000);
		add_instr(OP_MOV, 2, 0, SEL_IMM, 32'hFFFF_FFFF);
		add_instr(OP_DIV, 3, 1, 2, 0);
		add_instr(OP_REM, 3, 1, 2, 0);
		add_instr(OP_DIV, 3, 1, SEL_IMM, 0);
		add_instr(OP_MUL, 7, 1, 2, 0);
		add_instr(OP_ADD, 4, 7, SEL_IMM, 32'h7FFF_FFFF);
		add_instr(OP_SUB, 4, 4, 2, 0);
		for (int o = OP_NE; o <= OP_LE; o++) add_instr(5'(o), 3, 1, 2, 0);
		add_instr(OP_LOAD, 3, 1, SEL_IMM, 4);
		add_instr(OP_SAVE, 1, 2, SEL_IMM, 2);
		add_instr(OP_SAVE, 0, 2, SEL_IMM, 4);
		add_instr(OP_LOAD, 6, 0, SEL_IMM, 4);
		add_instr(OP_JZ, 0, 0, 0, 32'hFFFF_FFFF);
		add_instr(OP_JUMP, 0, 0, 0, 32'h0000_1FFF);
		add_instr(OP_CALL, 0, 0, 0, 32'd100);
		add_instr(5'd31, 0, 0, 0, 0);
		wait_drained();

		write_stack_top(19'd0);
		add_instr(OP_PUSH, 0, 0, SEL_IMM, 1);
		add_instr(OP_POP, 5, 0, 0, 0);
		add_instr(OP_CALL, 0, 0, 0, 5);
		wait_drained();

		// random phases over several stack settings
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_stack_top(19'd256);
				1: write_stack_top(19'h7FFFF);
				2: write_stack_top(19'd1024);
				default: write_stack_top(19'($urandom_range(0, 512)) << 2);
			endcase
			for (int i = 0; i < 100; i++) begin
				add_random();
				if (i == 50) wait_drained();
			end
			wait_drained();
		end
		stim_done = 1;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			send_gap <= 0;
		end else if (s_tvalid && !s_tready) begin
		end else if (send_gap > 0) begin
			s_tvalid <= 1'b0;
			send_gap <= send_gap - 1;
		end else if (pending_instrs.size() != 0) begin
			instr_t ins;
			ins = pending_instrs.pop_front();
			expected_outcomes.push_back(execute_instr(ins));
			s_tuser <= ins.op;
			s_tdata <= {3'd0, ins.pc, ins.imm, ins.s2, ins.s1, ins.dst};
			s_tvalid <= 1'b1;
			send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			recv_gap <= 0;
			idle_cycles <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("unexpected beat", 32'(m_tdata[11:0]), 0);
				end else begin
					outcome_t e;
					e = expected_outcomes.pop_front();
					if (m_tdata[11:0] !== e.npc) report_mismatch("next_pc", 32'(m_tdata[11:0]), 32'(e.npc));
					if (m_tdata[43:12] !== e.val) report_mismatch("written_value", m_tdata[43:12], e.val);
					if (m_tdata[46:44] !== e.err) report_mismatch("error_code", 32'(m_tdata[46:44]), 32'(e.err));
				end
				recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end

			// watchdog; allows for the memory clearing pass after reset
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles > 200000) begin
				$display("FAILED: results differ");
				$finish;
			end else if (stim_done) begin
				if (mismatches == 0 && expected_outcomes.size() == 0)
					$display("PASSED: all results match");
				else
					$display("FAILED: results differ");
				$finish;
			end
		end
	end

endmodule
